// File: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int COUNT_W = 5;

   // request function codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] value;
      logic signed [15:0] priority_req;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic signed [31:0] removed_value;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [15:0] prio;
   } entry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type op;
      entry_type   item;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/stable_priority_queue_top.sv
// An accepted request beat leaves its response beat in a registered response slot.
// Throughput: one request beat per cycle while rsp_ready is high; every cell compares
// the new priority and shifts in the same cycle, so only rsp_ready can hold the flow.
// Reset clears the entry count and the response valid; cell storage keeps its
// contents and is only ever read below the entry count.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_top #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CntW = $clog2(CAPACITY + 1);

   // Entry count: the cells hold no valid bits, occupancy follows from the count.
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   // Response register parts the request side from the response side.
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   logic         req_accept;
   logic         is_full;
   logic         is_empty;
   cell_ctl_type ctl;

   entry_type             cell_entry [CAPACITY];
   logic [CAPACITY-1:0]   cell_ge;
   logic [CAPACITY-1:0]   cell_occupied;

   // Take a new beat whenever the response slot is empty or draining this cycle.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign is_full    = (count_ff == CntW'(CAPACITY));
   assign is_empty   = (count_ff == '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Row of cells, head at cell 0. Each cell sees both neighbors: insert shifts
   // toward the tail past the cut point, remove shifts toward the head.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_ge;

      assign cell_occupied[i] = (CntW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_entry = ctl.item;
         assign left_ge    = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_ge    = cell_ge[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .left_ge     (left_ge),
         .occupied    (cell_occupied[i]),
         .entry       (cell_entry[i]),
         .ge          (cell_ge[i])
      );
   end

   // Decode the request into a cell command, the next count and the response.
   always_comb begin
      ctl.op        = CELL_HOLD;
      ctl.item.value = req_data.value;
      ctl.item.prio  = req_data.priority_req;
      count_in      = count_ff;

      rsp_data_in.status        = STATUS_DONE;
      rsp_data_in.removed_value = '0;

      if (req_accept) begin
         case (req_data.func)
            FUNC_INSERT: begin
               if (is_full) begin
                  // drop the item, report full
                  rsp_data_in.status = STATUS_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CntW'(1);
               end
            end
            FUNC_REMOVE: begin
               if (is_empty) begin
                  rsp_data_in.status = STATUS_EMPTY;
               end else begin
                  ctl.op                    = CELL_REMOVE;
                  rsp_data_in.removed_value = cell_entry[0].value;
                  count_in                  = count_ff - CntW'(1);
               end
            end
            default: begin
               ctl.op = CELL_HOLD;
            end
         endcase
      end

      // count is reported masked to the response field
      rsp_data_in.count = COUNT_W'(count_in);
   end

   // Load on accept, clear once the response beat leaves, else hold.
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("entry count beyond capacity");

   // An accepted request always leaves a response beat in the register.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("no response after accepted request");

   // A full report leaves the queue at capacity.
   a_full_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STATUS_FULL) |-> is_full)
      else $error("full status while queue not full");

   // An empty report leaves the queue empty and returns no value.
   a_empty_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STATUS_EMPTY)
         |-> (is_empty && rsp_data_ff.removed_value == '0))
      else $error("empty status with stored entries or a value");

endmodule

`default_nettype wire

// File: rtl/core/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::entry_type   left_entry,
   input  spq_pkg::entry_type   right_entry,
   input  logic                 left_ge,
   input  logic                 occupied,
   output spq_pkg::entry_type   entry,
   output logic                 ge
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // stay ahead of the new item when holding an equal or higher priority
   assign ge    = occupied && (entry_ff.prio >= ctl.item.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (!ge) begin
               // first cell past the cut takes the item, the rest shift down
               if (left_ge) begin
                  entry_in = ctl.item;
               end else begin
                  entry_in = left_entry;
               end
            end
         end
         CELL_REMOVE: begin
            entry_in = right_entry;
         end
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire
